@@ hw/rtl/smbg_pkg.sv @@
// ---------------------------------------------------------------------------
// Spectral mask bin gain package
// Shared widths, register indexes, scaling constants and the control bundle
// that travels alongside the ramp divider.
// ---------------------------------------------------------------------------
package smbg_pkg;

   // Transform size: bin_index covers exactly one transform
   localparam int FFT_POINTS  = 1024;
   localparam int HALF_POINTS = FFT_POINTS / 2;
   localparam int IDX_W       = $clog2(FFT_POINTS);

   // Datapath widths
   localparam int FREQ_W   = 36;
   localparam int GAIN_W   = 25;
   localparam int NUM_W    = 25;
   localparam int DEN_W    = 26;
   localparam int QUO_W    = 25;
   localparam int CSR_W    = 29;
   localparam int SAMPLE_W = 32;

   // Ramp divider: one quotient bit per step, several steps per stage
   localparam int DIV_STEPS       = QUO_W;
   localparam int DIV_STAGES      = 5;
   localparam int STEPS_PER_STAGE = DIV_STEPS / DIV_STAGES;

   // Whole pipeline, input word to result word
   localparam int PIPE_LAT = 17;
   // Sample delay until the output multiply
   localparam int X_DLY    = 15;

   localparam logic [GAIN_W-1:0] ONE_Q24 = 25'd16777216;

   // Register indexes
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_LOW_EDGE   = 3'd1;
   localparam logic [2:0] REG_HIGH_EDGE  = 3'd2;
   localparam logic [2:0] REG_CENTRE     = 3'd3;
   localparam logic [2:0] REG_CARRIER    = 3'd4;
   localparam logic [2:0] REG_SHARP      = 3'd5;
   localparam logic [2:0] REG_FLOOR      = 3'd6;
   localparam logic [2:0] REG_SPACING    = 3'd7;

   // Mode codes
   localparam logic [2:0] MODE_USB = 3'd3;
   localparam logic [2:0] MODE_LSB = 3'd4;

   // 3 kHz in 1/16 Hz
   localparam logic signed [FREQ_W-1:0] NEAR_SPAN = 36'sd48000;

   // Reciprocals for rounded division by constants
   localparam logic [31:0] RECIP_100  = 32'd42949673;   // 2^32 / 100, rounded up
   localparam logic [31:0] RECIP_10   = 32'd429496730;  // 2^32 / 10, rounded up
   localparam logic [31:0] RECIP_1000 = 32'd34359739;   // 2^35 / 1000, rounded up

   // Per-word control flags
   typedef struct packed {
      logic pass;
      logic ramp;
      logic opp;
      logic near;
      logic ssb;
      logic sharp;
   } ctl_type;

endpackage

@@ hw/rtl/smbg_div.sv @@
// ---------------------------------------------------------------------------
// Ramp divider
// Pipelined restoring divider giving floor(num * 2^25 / den) for num < den,
// with the control flags of each word carried alongside.
// ---------------------------------------------------------------------------
module smbg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [smbg_pkg::NUM_W-1:0]    in_num,
   input  logic [smbg_pkg::DEN_W-1:0]    in_den,
   input  smbg_pkg::ctl_type             in_ctl,
   output logic                          out_valid,
   output logic [smbg_pkg::QUO_W-1:0]    out_quo,
   output smbg_pkg::ctl_type             out_ctl
);

   logic                          v_ff   [smbg_pkg::DIV_STAGES];
   logic [smbg_pkg::DEN_W-1:0]    rem_ff [smbg_pkg::DIV_STAGES];
   logic [smbg_pkg::DEN_W-1:0]    den_ff [smbg_pkg::DIV_STAGES];
   logic [smbg_pkg::QUO_W-1:0]    quo_ff [smbg_pkg::DIV_STAGES];
   smbg_pkg::ctl_type             ctl_ff [smbg_pkg::DIV_STAGES];

   for (genvar s = 0; s < smbg_pkg::DIV_STAGES; s++) begin : g_stage
      logic                       v_src;
      logic [smbg_pkg::DEN_W-1:0] rem_src;
      logic [smbg_pkg::DEN_W-1:0] den_src;
      logic [smbg_pkg::QUO_W-1:0] quo_src;
      smbg_pkg::ctl_type          ctl_src;
      logic [smbg_pkg::DEN_W-1:0] rem_in;
      logic [smbg_pkg::QUO_W-1:0] quo_in;

      // Select the stage source
      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = smbg_pkg::DEN_W'(in_num);
         assign den_src = in_den;
         assign quo_src = '0;
         assign ctl_src = in_ctl;
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign ctl_src = ctl_ff[s-1];
      end

      // Shift, trial subtract, restore
      always_comb begin
         logic [smbg_pkg::DEN_W:0] r2;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int i = 0; i < smbg_pkg::STEPS_PER_STAGE; i++) begin
            r2 = {rem_in, 1'b0};
            if (r2 >= {1'b0, den_src}) begin
               rem_in = smbg_pkg::DEN_W'(r2 - {1'b0, den_src});
               quo_in = {quo_in[smbg_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = r2[smbg_pkg::DEN_W-1:0];
               quo_in = {quo_in[smbg_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src;
         end
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_src;
         quo_ff[s] <= quo_in;
         ctl_ff[s] <= ctl_src;
      end
   end

   assign out_valid = v_ff[smbg_pkg::DIV_STAGES-1];
   assign out_quo   = quo_ff[smbg_pkg::DIV_STAGES-1];
   assign out_ctl   = ctl_ff[smbg_pkg::DIV_STAGES-1];

endmodule

@@ hw/rtl/spectral_mask_bin_gain.sv @@
// ---------------------------------------------------------------------------
// Spectral mask bin gain
// Maps an FFT bin to a signed frequency, derives its passband mask gain and
// returns the bin scaled by that gain.
// ---------------------------------------------------------------------------
// One bin word is taken every clock (busy is low except during reset) and its
// result word appears at the end of the pipeline, strobed by rsp_valid for one
// cycle; the receiver cannot hold results off, so none is ever held back.
// The pipeline has 17 stages: frequency multiply, edge arithmetic, ramp
// compare, a five-stage ramp divider, mask gain, two smoothstep multiplies,
// two constant dividers, floor and gain select, output multiply and rounding.
// Configuration registers may be written only while no word is in flight.
module spectral_mask_bin_gain (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [smbg_pkg::IDX_W-1:0]           req_bin_index,
   input  logic signed [smbg_pkg::SAMPLE_W-1:0] req_bin_real,
   input  logic signed [smbg_pkg::SAMPLE_W-1:0] req_bin_imag,
   output logic                                 rsp_valid,
   output logic signed [smbg_pkg::SAMPLE_W-1:0] rsp_out_real,
   output logic signed [smbg_pkg::SAMPLE_W-1:0] rsp_out_imag,
   output logic [smbg_pkg::GAIN_W-1:0]          rsp_bin_gain,
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [smbg_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int FW = smbg_pkg::FREQ_W;
   localparam int GW = smbg_pkg::GAIN_W;
   localparam int SW = smbg_pkg::SAMPLE_W;

   // ---------------- configuration registers ----------------
   logic [2:0]          mode_ff;
   logic signed [28:0]  low_ff;
   logic signed [28:0]  high_ff;
   logic signed [28:0]  centre_ff;
   logic signed [28:0]  carrier_ff;
   logic                sharp_ff;
   logic [24:0]         floor_ff;
   logic [23:0]         spacing_ff;

   // Take a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 3'd0;
         low_ff     <= -29'sd1600000;
         high_ff    <= 29'sd1600000;
         centre_ff  <= '0;
         carrier_ff <= '0;
         sharp_ff   <= 1'b0;
         floor_ff   <= 25'd2983;
         spacing_ff <= 24'd32000;
      end else if (csr_we) begin
         unique case (csr_index)
            smbg_pkg::REG_MODE:      mode_ff    <= csr_wdata[2:0];
            smbg_pkg::REG_LOW_EDGE:  low_ff     <= csr_wdata;
            smbg_pkg::REG_HIGH_EDGE: high_ff    <= csr_wdata;
            smbg_pkg::REG_CENTRE:    centre_ff  <= csr_wdata;
            smbg_pkg::REG_CARRIER:   carrier_ff <= csr_wdata;
            smbg_pkg::REG_SHARP:     sharp_ff   <= csr_wdata[0];
            smbg_pkg::REG_FLOOR:     floor_ff   <= csr_wdata[24:0];
            smbg_pkg::REG_SPACING:   spacing_ff <= csr_wdata[23:0];
            default:                 mode_ff    <= mode_ff;
         endcase
      end
   end

   // Derived configuration
   logic        is_usb;
   logic        is_lsb;
   logic        is_ssb;
   logic [23:0] sp_eff;
   logic [24:0] floor_eff;
   assign is_usb    = (mode_ff == smbg_pkg::MODE_USB);
   assign is_lsb    = (mode_ff == smbg_pkg::MODE_LSB);
   assign is_ssb    = is_usb || is_lsb;
   assign sp_eff    = (spacing_ff == '0) ? 24'd1 : spacing_ff;
   assign floor_eff = (floor_ff > smbg_pkg::ONE_Q24) ? smbg_pkg::ONE_Q24 : floor_ff;

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------- sample delay line ----------------
   logic signed [SW-1:0] xr_ff [smbg_pkg::X_DLY];
   logic signed [SW-1:0] xi_ff [smbg_pkg::X_DLY];

   always_ff @(posedge clock) begin
      xr_ff[0] <= req_bin_real;
      xi_ff[0] <= req_bin_imag;
      for (int i = 1; i < smbg_pkg::X_DLY; i++) begin
         xr_ff[i] <= xr_ff[i-1];
         xi_ff[i] <= xi_ff[i-1];
      end
   end

   // ---------------- stage 1: bin frequency ----------------
   localparam int IDX_PLUS = smbg_pkg::IDX_W + 1;
   logic signed [IDX_PLUS-1:0] k_in;
   logic                 v1_ff;
   logic signed [FW-1:0] f1_ff;

   always_comb begin
      if (req_bin_index > smbg_pkg::IDX_W'(smbg_pkg::HALF_POINTS)) begin
         k_in = $signed({1'b0, req_bin_index})
                - IDX_PLUS'(smbg_pkg::FFT_POINTS);
      end else begin
         k_in = $signed({1'b0, req_bin_index});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      f1_ff <= FW'(k_in * $signed({1'b0, sp_eff}));
   end

   // ---------------- stage 2: passband edges ----------------
   logic signed [FW-1:0] lo_in;
   logic signed [FW-1:0] hi_in;
   logic [25:0]          t_in;
   logic                 v2_ff;
   logic signed [FW-1:0] f2_ff;
   logic signed [FW-1:0] lo2_ff;
   logic signed [FW-1:0] hi2_ff;
   logic signed [FW-1:0] lot2_ff;
   logic signed [FW-1:0] hit2_ff;
   logic signed [FW-1:0] d2_ff;
   logic [25:0]          t2_ff;

   always_comb begin
      lo_in = FW'(low_ff) + FW'(centre_ff);
      hi_in = FW'(high_ff) + FW'(centre_ff);
      if (is_ssb) begin
         lo_in = lo_in + FW'(carrier_ff);
         hi_in = hi_in + FW'(carrier_ff);
         t_in  = {2'b00, sp_eff};
      end else begin
         t_in  = {1'b0, sp_eff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      f2_ff   <= f1_ff;
      lo2_ff  <= lo_in;
      hi2_ff  <= hi_in;
      lot2_ff <= lo_in - $signed({10'd0, t_in});
      hit2_ff <= hi_in + $signed({10'd0, t_in});
      d2_ff   <= f1_ff - FW'(centre_ff);
      t2_ff   <= t_in;
   end

   // ---------------- stage 3: ramp selection ----------------
   logic                       low_ramp;
   logic                       high_ramp;
   logic signed [FW-1:0]       num_full;
   logic                       v3_ff;
   logic [smbg_pkg::NUM_W-1:0] num3_ff;
   logic [smbg_pkg::DEN_W-1:0] den3_ff;
   smbg_pkg::ctl_type          ctl_in;
   smbg_pkg::ctl_type          ctl3_ff;

   always_comb begin
      low_ramp  = (f2_ff >= lot2_ff) && (f2_ff < lo2_ff);
      high_ramp = (f2_ff > hi2_ff) && (f2_ff <= hit2_ff);
      num_full  = '0;
      // low ramp takes precedence over the high ramp
      priority if (low_ramp) begin
         num_full = f2_ff - lot2_ff;
      end else if (high_ramp) begin
         num_full = hit2_ff - f2_ff;
      end else begin
         num_full = '0;
      end
      ctl_in.pass  = (f2_ff >= lo2_ff) && (f2_ff <= hi2_ff);
      ctl_in.ramp  = (!is_ssb || sharp_ff) && (low_ramp || high_ramp);
      ctl_in.opp   = (is_usb && (d2_ff < 0)) || (is_lsb && (d2_ff > 0));
      ctl_in.near  = (d2_ff < smbg_pkg::NEAR_SPAN) && (d2_ff > -smbg_pkg::NEAR_SPAN);
      ctl_in.ssb   = is_ssb;
      ctl_in.sharp = sharp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      num3_ff <= num_full[smbg_pkg::NUM_W-1:0];
      den3_ff <= t2_ff;
      ctl3_ff <= ctl_in;
   end

   // ---------------- stages 4 to 8: ramp divider ----------------
   logic                       v8;
   logic [smbg_pkg::QUO_W-1:0] quo8;
   smbg_pkg::ctl_type          ctl8;

   smbg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num3_ff),
      .in_den    (den3_ff),
      .in_ctl    (ctl3_ff),
      .out_valid (v8),
      .out_quo   (quo8),
      .out_ctl   (ctl8)
   );

   // ---------------- stage 9: mask gain ----------------
   logic [smbg_pkg::QUO_W:0] quo_rnd;
   logic                     v9_ff;
   logic [GW-1:0]            g9_ff;
   smbg_pkg::ctl_type        ctl9_ff;

   assign quo_rnd = ({1'b0, quo8} + 26'd1) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8;
      end
      priority if (ctl8.pass) begin
         g9_ff <= smbg_pkg::ONE_Q24;
      end else if (ctl8.ramp) begin
         g9_ff <= quo_rnd[GW-1:0];
      end else begin
         g9_ff <= '0;
      end
      ctl9_ff <= ctl8;
   end

   // ---------------- stage 10: t squared ----------------
   logic [2*GW-1:0]   sq_in;
   logic              v10_ff;
   logic [GW-1:0]     g10_ff;
   logic [GW-1:0]     tt10_ff;
   smbg_pkg::ctl_type ctl10_ff;

   assign sq_in = g9_ff * g9_ff + (2*GW)'(1 << 23);

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      g10_ff   <= g9_ff;
      tt10_ff  <= sq_in[24 +: GW];
      ctl10_ff <= ctl9_ff;
   end

   // ---------------- stage 11: smoothstep ----------------
   logic [25:0]       kk_in;
   logic [50:0]       sm_in;
   logic              v11_ff;
   logic [GW-1:0]     g11_ff;
   smbg_pkg::ctl_type ctl11_ff;

   assign kk_in = 26'(3 * 16777216) - {g10_ff, 1'b0};
   assign sm_in = tt10_ff * kk_in + 51'(1 << 23);

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else begin
         v11_ff <= v10_ff;
      end
      // smoothstep leaves 0 and 1 unchanged, so apply it to every sideband word
      g11_ff   <= ctl10_ff.ssb ? sm_in[24 +: GW] : g10_ff;
      ctl11_ff <= ctl10_ff;
   end

   // ---------------- stage 12: divide by 100 ----------------
   logic              v12_ff;
   logic [GW-1:0]     g12_ff;
   logic [56:0]       p12_ff;
   smbg_pkg::ctl_type ctl12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else begin
         v12_ff <= v11_ff;
      end
      g12_ff   <= g11_ff;
      p12_ff   <= 57'({1'b0, g11_ff} + 26'd50) * 57'(smbg_pkg::RECIP_100);
      ctl12_ff <= ctl11_ff;
   end

   // ---------------- stage 13: opposite sideband and floor ----------------
   logic [GW-1:0]     g_sel;
   logic              v13_ff;
   logic [GW-1:0]     g13_ff;
   smbg_pkg::ctl_type ctl13_ff;

   always_comb begin
      if (ctl12_ff.ssb && ctl12_ff.sharp && ctl12_ff.opp) begin
         g_sel = p12_ff[32 +: GW];
      end else begin
         g_sel = g12_ff;
      end
      if (g_sel < floor_eff) begin
         g_sel = floor_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_ff <= 1'b0;
      end else begin
         v13_ff <= v12_ff;
      end
      g13_ff   <= g_sel;
      ctl13_ff <= ctl12_ff;
   end

   // ---------------- stage 14: divide by 1000 or 10 ----------------
   logic              v14_ff;
   logic [GW-1:0]     g14_ff;
   logic [57:0]       p14_ff;
   smbg_pkg::ctl_type ctl14_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff <= 1'b0;
      end else begin
         v14_ff <= v13_ff;
      end
      g14_ff <= g13_ff;
      if (ctl13_ff.near) begin
         p14_ff <= 58'({1'b0, g13_ff} + 26'd500) * 58'(smbg_pkg::RECIP_1000);
      end else begin
         p14_ff <= 58'({1'b0, g13_ff} + 26'd5) * 58'(smbg_pkg::RECIP_10);
      end
      ctl14_ff <= ctl13_ff;
   end

   // ---------------- stage 15: final gain ----------------
   logic          v15_ff;
   logic [GW-1:0] g15_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v15_ff <= 1'b0;
      end else begin
         v15_ff <= v14_ff;
      end
      priority if (!(ctl14_ff.ssb && ctl14_ff.opp)) begin
         g15_ff <= g14_ff;
      end else if (ctl14_ff.near) begin
         g15_ff <= p14_ff[35 +: GW];
      end else begin
         g15_ff <= p14_ff[32 +: GW];
      end
   end

   // ---------------- stage 16: scale the bin ----------------
   localparam int PW = SW + GW + 1;
   logic                 v16_ff;
   logic [GW-1:0]        g16_ff;
   logic signed [PW-1:0] pr16_ff;
   logic signed [PW-1:0] pi16_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v16_ff <= 1'b0;
      end else begin
         v16_ff <= v15_ff;
      end
      g16_ff  <= g15_ff;
      pr16_ff <= PW'(xr_ff[smbg_pkg::X_DLY-1] * $signed({1'b0, g15_ff}));
      pi16_ff <= PW'(xi_ff[smbg_pkg::X_DLY-1] * $signed({1'b0, g15_ff}));
   end

   // ---------------- stage 17: round and saturate ----------------
   function automatic logic signed [SW-1:0] round_sat(input logic signed [PW-1:0] p);
      logic [PW-1:0]        mag;
      logic [PW-1:0]        rq;
      logic signed [PW-1:0] q;
      mag = p[PW-1] ? PW'(-p) : PW'(p);
      rq  = (mag + PW'(1 << 23)) >> 24;
      q   = p[PW-1] ? -$signed(rq) : $signed(rq);
      if (q > PW'(2147483647)) begin
         return 32'sh7FFF_FFFF;
      end else if (q < -$signed(PW'(64'd2147483648))) begin
         return 32'sh8000_0000;
      end else begin
         return q[SW-1:0];
      end
   endfunction

   logic                 v17_ff;
   logic signed [SW-1:0] or17_ff;
   logic signed [SW-1:0] oi17_ff;
   logic [GW-1:0]        g17_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v17_ff <= 1'b0;
      end else begin
         v17_ff <= v16_ff;
      end
      or17_ff <= round_sat(pr16_ff);
      oi17_ff <= round_sat(pi16_ff);
      g17_ff  <= g16_ff;
   end

   assign rsp_valid    = v17_ff;
   assign rsp_out_real = or17_ff;
   assign rsp_out_imag = oi17_ff;
   assign rsp_bin_gain = g17_ff;

endmodule

@@ hw/rtl/smbg_chk.sv @@
// ---------------------------------------------------------------------------
// Spectral mask bin gain checker
// Port-level checks on latency, gain range and unity-gain pass-through.
// ---------------------------------------------------------------------------
module smbg_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [smbg_pkg::SAMPLE_W-1:0] req_bin_real,
   input logic signed [smbg_pkg::SAMPLE_W-1:0] req_bin_imag,
   input logic                                 rsp_valid,
   input logic signed [smbg_pkg::SAMPLE_W-1:0] rsp_out_real,
   input logic signed [smbg_pkg::SAMPLE_W-1:0] rsp_out_imag,
   input logic [smbg_pkg::GAIN_W-1:0]          rsp_bin_gain
);

   // Every accepted word yields a result after the fixed latency
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(smbg_pkg::PIPE_LAT) rsp_valid)
      else $error("accepted word gave no result");

   // No result without a word accepted the latency before
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, smbg_pkg::PIPE_LAT))
      else $error("result without accepted word");

   // Gain never exceeds unity
   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bin_gain <= smbg_pkg::ONE_Q24))
      else $error("gain above unity");

   // Unity gain passes the bin unchanged
   a_unity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_bin_gain == smbg_pkg::ONE_Q24)) |->
         ((rsp_out_real == $past(req_bin_real, smbg_pkg::PIPE_LAT)) &&
          (rsp_out_imag == $past(req_bin_imag, smbg_pkg::PIPE_LAT))))
      else $error("unity gain altered the bin");

endmodule

bind spectral_mask_bin_gain smbg_chk u_smbg_chk (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_bin_real (req_bin_real),
   .req_bin_imag (req_bin_imag),
   .rsp_valid    (rsp_valid),
   .rsp_out_real (rsp_out_real),
   .rsp_out_imag (rsp_out_imag),
   .rsp_bin_gain (rsp_bin_gain)
);
